// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define WSFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wsfd assertion failed");
`define WSFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");
`else
`define WSFD_ASSERT(lbl, prop)
`define WSFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Constants, queue entry and result types shared by the decoder modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Queue depth must be a power of two.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  typedef enum logic [2:0] {
    K_HDR0,
    K_HDR1,
    K_EXT,
    K_KEY,
    K_DATA
  } wsfd_kind_t;

  typedef struct packed {
    wsfd_kind_t kind;
    logic [7:0] data;
    logic       emit;
    logic       last;
  } wsfd_op_t;

  typedef struct packed {
    logic        has_payload_byte;
    logic [7:0]  payload_byte;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [3:0]  header_length;
    logic        last_of_frame;
  } wsfd_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsfd_qstat_t;

endpackage

// File: rtl/wsfd_in_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one raw stream byte per item.
// ----------------------------------------------------------------------------
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: rtl/wsfd_out_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one decoded payload item with frame fields.
// ----------------------------------------------------------------------------
interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic        has_payload_byte;
  logic [7:0]  payload_byte;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [3:0]  header_length;
  logic        last_of_frame;

  modport source (
    output valid, output has_payload_byte, output payload_byte, output fin,
    output opcode, output masked, output payload_length, output header_length,
    output last_of_frame, input ready
  );
  modport sink (
    input valid, input has_payload_byte, input payload_byte, input fin,
    input opcode, input masked, input payload_length, input header_length,
    input last_of_frame, output ready
  );
endinterface

// File: rtl/wsfd_queue.sv
// ----------------------------------------------------------------------------
// Classified byte queue
// Small show-ahead FIFO between the parsing front and the decoding back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsfd_pkg::wsfd_op_t  push_op,
  input  logic                pop,
  output wsfd_pkg::wsfd_op_t  head_op,
  output wsfd_pkg::wsfd_qstat_t stat
);
  import wsfd_pkg::*;

  wsfd_op_t         mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r;
  logic [QAw-1:0]   rd_ptr_r;
  logic [QAw:0]     count_r;
  logic [QAw:0]     count_nxt;

  assign stat.full  = (count_r == (QAw+1)'(QDepth));
  assign stat.empty = (count_r == '0);
  assign head_op    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `WSFD_ASSERT(a_count_bound, count_r <= (QAw+1)'(QDepth))
  `WSFD_ASSERT_NEXT(a_ptr_gap, 1'b1, (wr_ptr_r - rd_ptr_r) == count_r[QAw-1:0])

endmodule

// File: rtl/wsfd_front.sv
// ----------------------------------------------------------------------------
// Frame parser front
// Accepts stream bytes, tracks frame boundaries and tags each byte for the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  wsfd_in_if.sink               in_byte,
  input  wsfd_pkg::wsfd_qstat_t qstat,
  output logic                  push,
  output wsfd_pkg::wsfd_op_t    push_op
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  b;
  logic [6:0]  len7;

  assign in_byte.ready = !qstat.full;
  assign push          = in_byte.valid && in_byte.ready;
  assign b             = in_byte.data_byte;
  assign len7          = b[6:0];

  always_comb begin
    phase_nxt    = phase_r;
    masked_nxt   = masked_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    push_op.kind = K_HDR0;
    push_op.data = b;
    push_op.emit = 1'b0;
    push_op.last = 1'b0;
    case (phase_r)
      PH_HDR1: begin
        push_op.kind = K_HDR1;
        masked_nxt   = b[7];
        if (len7 == Len16Code) begin
          len_nxt   = '0;
          cnt_nxt   = Ext16Bytes;
          phase_nxt = PH_EXT;
        end else if (len7 == Len64Code) begin
          len_nxt   = '0;
          cnt_nxt   = Ext64Bytes;
          phase_nxt = PH_EXT;
        end else begin
          len_nxt = {57'd0, len7};
          if (b[7]) begin
            cnt_nxt   = KeyBytes;
            phase_nxt = PH_KEY;
          end else if (len7 == 7'd0) begin
            push_op.emit = 1'b1;
            push_op.last = 1'b1;
            phase_nxt    = PH_HDR0;
          end else begin
            rem_nxt   = {57'd0, len7};
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        push_op.kind = K_EXT;
        len_nxt      = {len_r[55:0], b};
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == 4'd1) begin
          if (masked_r) begin
            cnt_nxt   = KeyBytes;
            phase_nxt = PH_KEY;
          end else if (len_nxt == '0) begin
            push_op.emit = 1'b1;
            push_op.last = 1'b1;
            phase_nxt    = PH_HDR0;
          end else begin
            rem_nxt   = len_nxt;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_KEY: begin
        push_op.kind = K_KEY;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == 4'd1) begin
          if (len_r == '0) begin
            push_op.emit = 1'b1;
            push_op.last = 1'b1;
            phase_nxt    = PH_HDR0;
          end else begin
            rem_nxt   = len_r;
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        push_op.kind = K_DATA;
        push_op.emit = 1'b1;
        rem_nxt      = rem_r - 1'b1;
        if (rem_r == 64'd1) begin
          push_op.last = 1'b1;
          phase_nxt    = PH_HDR0;
        end
      end
      default: begin
        push_op.kind = K_HDR0;
        phase_nxt    = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      masked_r <= 1'b0;
      len_r    <= '0;
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (push) begin
      phase_r  <= phase_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `WSFD_ASSERT(a_data_rem, (phase_r != PH_DATA) || (rem_r != '0))

endmodule

// File: rtl/wsfd_back.sv
// ----------------------------------------------------------------------------
// Frame decoder back
// Keeps the frame header fields, unmasks payload bytes and drives the results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsfd_pkg::wsfd_op_t    head_op,
  input  wsfd_pkg::wsfd_qstat_t qstat,
  output logic                  pop,
  wsfd_out_if.source            out_res
);
  import wsfd_pkg::*;

  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kpos_r, kpos_nxt;
  logic [7:0]  kb;
  logic [7:0]  b;
  logic        out_valid_r;
  wsfd_res_t   res_r, res_nxt;

  assign b   = head_op.data;
  assign pop = !qstat.empty && (!head_op.emit || !out_valid_r || out_res.ready);

  always_comb begin
    case (kpos_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
    if (!masked_r) begin
      kb = 8'd0;
    end
  end

  always_comb begin
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    hcnt_nxt   = hcnt_r;
    key_nxt    = key_r;
    kpos_nxt   = kpos_r;
    case (head_op.kind)
      K_HDR0: begin
        fin_nxt    = b[7];
        opcode_nxt = b[3:0];
        hcnt_nxt   = 4'd1;
      end
      K_HDR1: begin
        masked_nxt = b[7];
        hcnt_nxt   = 4'd2;
        key_nxt    = '0;
        kpos_nxt   = '0;
        if ((b[6:0] == Len16Code) || (b[6:0] == Len64Code)) begin
          len_nxt = '0;
        end else begin
          len_nxt = {57'd0, b[6:0]};
        end
      end
      K_EXT: begin
        len_nxt  = {len_r[55:0], b};
        hcnt_nxt = hcnt_r + 1'b1;
      end
      K_KEY: begin
        key_nxt  = {key_r[23:0], b};
        hcnt_nxt = hcnt_r + 1'b1;
      end
      K_DATA: begin
        kpos_nxt = kpos_r + 1'b1;
      end
      default: begin
        fin_nxt = fin_r;
      end
    endcase

    res_nxt.has_payload_byte = (head_op.kind == K_DATA);
    res_nxt.payload_byte     = (head_op.kind == K_DATA) ? (b ^ kb) : 8'd0;
    res_nxt.fin              = fin_nxt;
    res_nxt.opcode           = opcode_nxt;
    res_nxt.masked           = masked_nxt;
    res_nxt.payload_length   = len_nxt;
    res_nxt.header_length    = hcnt_nxt;
    res_nxt.last_of_frame    = head_op.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r       <= 1'b0;
      opcode_r    <= '0;
      masked_r    <= 1'b0;
      len_r       <= '0;
      hcnt_r      <= '0;
      key_r       <= '0;
      kpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        fin_r    <= fin_nxt;
        opcode_r <= opcode_nxt;
        masked_r <= masked_nxt;
        len_r    <= len_nxt;
        hcnt_r   <= hcnt_nxt;
        key_r    <= key_nxt;
        kpos_r   <= kpos_nxt;
      end
      if (pop && head_op.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.has_payload_byte = res_r.has_payload_byte;
  assign out_res.payload_byte     = res_r.payload_byte;
  assign out_res.fin              = res_r.fin;
  assign out_res.opcode           = res_r.opcode;
  assign out_res.masked           = res_r.masked;
  assign out_res.payload_length   = res_r.payload_length;
  assign out_res.header_length    = res_r.header_length;
  assign out_res.last_of_frame    = res_r.last_of_frame;

  `WSFD_ASSERT(a_empty_is_last, !out_valid_r || res_r.has_payload_byte || res_r.last_of_frame)
  `WSFD_ASSERT(a_hdr_len_min, !out_valid_r || (res_r.header_length >= 4'd2))

endmodule

// File: rtl/websocket_frame_decoder.sv
// Path: an accepted byte is stored in the queue; any result it gives is registered.
// One byte per cycle unless the queue is full; headers of non-empty frames give no result.
// A four-entry queue between parser and decoder absorbs output stalls.
// Reset: synchronous active-low rst_n clears parse state, queue pointers and output valid.
// ----------------------------------------------------------------------------
// WebSocket frame decoder
// Byte-serial frame parser with unmasking, built as a front, a queue and a back.
// ----------------------------------------------------------------------------
module websocket_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  wsfd_in_if.sink    in_byte,
  wsfd_out_if.source out_res
);
  import wsfd_pkg::*;

  logic        push;
  logic        pop;
  wsfd_op_t    push_op;
  wsfd_op_t    head_op;
  wsfd_qstat_t qstat;

  wsfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .qstat   (qstat),
    .push    (push),
    .push_op (push_op)
  );

  wsfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (qstat)
  );

  wsfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_op (head_op),
    .qstat   (qstat),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule
